// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/tlbt_pkg.sv =====
// types and constants of the tlb translator
package tlbt_pkg;

  localparam int unsigned TLB_ENTRIES = 16;
  localparam int unsigned PAGE_COUNT  = 256;
  localparam int unsigned FRAME_COUNT = 128;
  localparam int unsigned OFFSET_BITS = 8;

  localparam int unsigned VA_W    = 16;
  localparam int unsigned PA_W    = 15;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned PAGE_W  = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
  localparam int unsigned FREE_W  = $clog2(FRAME_COUNT + 1);
  localparam int unsigned TIDX_W  = $clog2(TLB_ENTRIES);
  localparam int unsigned RANK_W  = $clog2(TLB_ENTRIES + 1);

  typedef logic [PAGE_W-1:0]      page_t;
  typedef logic [FRAME_W-1:0]     frame_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [TIDX_W-1:0]      tidx_t;
  typedef logic [RANK_W-1:0]      rank_t;
  typedef logic [CNT_W-1:0]       count_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture the input address
    logic lookup;     // tlb search, counters, frame choice
    logic pt_load;    // frame from page table
    logic evict;      // invalidate victim page, drop its tlb entry
    logic fill;       // page table and reverse map writes
    logic tlb_ins;    // new tlb entry
    logic push;       // new frame to the front of the lru list
    logic mv_unlink;  // take frame out of the lru list
    logic mv_link;    // put frame at the front of the lru list
    logic out_load;   // load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic tlb_hit;
    logic page_resident;
    logic free_avail;
    logic frame_is_head;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/tlbt_if.sv =====
// transfer channels of the tlb translator

interface tlbt_in_if;
  logic                      valid;
  logic                      ready;
  logic [tlbt_pkg::VA_W-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

interface tlbt_out_if;
  logic                       valid;
  logic                       ready;
  logic [tlbt_pkg::PA_W-1:0]  physical_address;
  logic                       tlb_hit;
  logic                       page_fault;
  logic                       evicted_valid;
  logic [7:0]                 evicted_page;
  logic [tlbt_pkg::CNT_W-1:0] hit_total;
  logic [tlbt_pkg::CNT_W-1:0] fault_total;

  modport source (output valid, output physical_address, output tlb_hit, output page_fault,
                  output evicted_valid, output evicted_page, output hit_total,
                  output fault_total, input ready);
  modport sink (input valid, input physical_address, input tlb_hit, input page_fault,
                input evicted_valid, input evicted_page, input hit_total,
                input fault_total, output ready);
endinterface

// ===== hw/rtl/tlb_page_table_lru_translator.sv =====
// top level of the tlb translator with demand paging
//
// in_ch carries one 16-bit virtual address per transfer (page in bits 15..8,
// offset in bits 7..0); out_ch returns one result per address: physical
// address, tlb hit and page fault flags, the evicted page if any, and the
// running hit and fault counts after this access.
// One address is handled at a time; in_ch.ready is high only while idle.
// The frame lru order is a linked list in two memories of forward and
// backward links; moving a frame to the front of that list reads its
// links, unlinks it and links it in at the front, and is skipped when the
// frame is already the most recently used one or a fresh frame is pushed.
// in_ch.ready is high again in the cycle after the result is registered.
// Reset (rst, synchronous) empties the tlb, marks every page non-resident,
// empties the frame list and clears both counters; no clearing pass is run.
// When out_ch.ready is low the result holds in its register and the block
// finishes the next address only up to its result, then waits.
// A fault tells the outside agent to fill the given frame with the page.
module tlb_page_table_lru_translator (
  input logic         clk,
  input logic         rst,
  tlbt_in_if.sink     in_ch,
  tlbt_out_if.source  out_ch
);

  tlbt_pkg::cmd_t  cmd;
  tlbt_pkg::stat_t stat;

  tlbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlbt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .va_in           (in_ch.virtual_address),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_pa          (out_ch.physical_address),
    .out_hit         (out_ch.tlb_hit),
    .out_fault       (out_ch.page_fault),
    .out_ev_valid    (out_ch.evicted_valid),
    .out_ev_page     (out_ch.evicted_page),
    .out_hit_total   (out_ch.hit_total),
    .out_fault_total (out_ch.fault_total)
  );

endmodule

// ===== hw/rtl/tlbt_ctrl.sv =====
// sequencing state machine of the tlb translator
module tlbt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlbt_pkg::stat_t stat,
  output tlbt_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_PTREAD, S_INS, S_NEWF, S_EVICT, S_FILL,
    S_MOVE0, S_MOVE1, S_MOVE2, S_DONE
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (stat.tlb_hit) begin
          state_next = S_MOVE0;
        end else if (stat.page_resident) begin
          state_next = S_PTREAD;
        end else if (stat.free_avail) begin
          state_next = S_NEWF;
        end else begin
          state_next = S_EVICT;
        end
      end
      S_PTREAD: begin
        cmd.pt_load = 1'b1;
        state_next  = S_INS;
      end
      S_INS: begin
        cmd.tlb_ins = 1'b1;
        state_next  = S_MOVE0;
      end
      S_NEWF: begin
        cmd.fill    = 1'b1;
        cmd.tlb_ins = 1'b1;
        cmd.push    = 1'b1;
        state_next  = S_DONE;
      end
      S_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill    = 1'b1;
        cmd.tlb_ins = 1'b1;
        state_next  = S_MOVE0;
      end
      S_MOVE0: begin
        state_next = stat.frame_is_head ? S_DONE : S_MOVE1;
      end
      S_MOVE1: begin
        cmd.mv_unlink = 1'b1;
        state_next    = S_MOVE2;
      end
      S_MOVE2: begin
        cmd.mv_link = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tlbt_datapath.sv =====
// tlb, page table, frame lru list and result register
module tlbt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tlbt_pkg::cmd_t              cmd,
  output tlbt_pkg::stat_t             stat,
  input  logic [tlbt_pkg::VA_W-1:0]   va_in,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [tlbt_pkg::PA_W-1:0]   out_pa,
  output logic                        out_hit,
  output logic                        out_fault,
  output logic                        out_ev_valid,
  output logic [7:0]                  out_ev_page,
  output tlbt_pkg::count_t            out_hit_total,
  output tlbt_pkg::count_t            out_fault_total
);

  localparam int unsigned NT = tlbt_pkg::TLB_ENTRIES;

  // item registers
  tlbt_pkg::page_t   page_q;
  tlbt_pkg::offset_t off_q;
  tlbt_pkg::frame_t  frame_q;
  logic              hit_q, fault_q, ev_valid_q;
  tlbt_pkg::page_t   ev_page_q;
  tlbt_pkg::count_t  hit_cnt, fault_cnt;
  logic [tlbt_pkg::FREE_W-1:0] next_free;
  tlbt_pkg::frame_t  head, tail;

  // tlb entries
  tlbt_pkg::page_t  tag [NT];
  tlbt_pkg::frame_t tfr [NT];
  tlbt_pkg::rank_t  rank [NT];

  // page table, reverse map and lru links
  logic [tlbt_pkg::PAGE_COUNT-1:0] pvalid;
  tlbt_pkg::frame_t pmap_mem [tlbt_pkg::PAGE_COUNT];
  tlbt_pkg::page_t  fpage_mem [tlbt_pkg::FRAME_COUNT];
  tlbt_pkg::frame_t fnext_mem [tlbt_pkg::FRAME_COUNT];
  tlbt_pkg::frame_t fprev_mem [tlbt_pkg::FRAME_COUNT];
  tlbt_pkg::frame_t pmap_rd, fnext_rd, fprev_rd;
  tlbt_pkg::page_t  fpage_rd;

  logic            hit_any, ins_empty, rm_any;
  tlbt_pkg::tidx_t hit_idx, empty_idx, old_idx, ins_idx, rm_idx;

  // tlb search, insert slot and remove match
  always_comb begin
    hit_any   = 1'b0;
    hit_idx   = '0;
    ins_empty = 1'b0;
    empty_idx = '0;
    old_idx   = '0;
    rm_any    = 1'b0;
    rm_idx    = '0;
    for (int i = NT - 1; i >= 0; i--) begin
      if (rank[i] != '0 && tag[i] == page_q) begin
        hit_any = 1'b1;
        hit_idx = tlbt_pkg::TIDX_W'(i);
      end
      if (rank[i] == '0) begin
        ins_empty = 1'b1;
        empty_idx = tlbt_pkg::TIDX_W'(i);
      end
      if (rank[i] == tlbt_pkg::RANK_W'(NT)) begin
        old_idx = tlbt_pkg::TIDX_W'(i);
      end
      if (rank[i] != '0 && tag[i] == fpage_rd && tfr[i] == frame_q) begin
        rm_any = 1'b1;
        rm_idx = tlbt_pkg::TIDX_W'(i);
      end
    end
    ins_idx = ins_empty ? empty_idx : old_idx;
  end

  always_comb begin
    stat.tlb_hit       = hit_any;
    stat.page_resident = pvalid[page_q];
    stat.free_avail    = next_free < tlbt_pkg::FREE_W'(tlbt_pkg::FRAME_COUNT);
    stat.frame_is_head = frame_q == head;
    stat.out_free      = !out_valid || out_ready;
  end

  // tlb lru ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NT; i++) rank[i] <= '0;
    end else if (cmd.lookup && hit_any) begin
      for (int i = 0; i < NT; i++) begin
        if (rank[i] != '0 && rank[i] < rank[hit_idx]) rank[i] <= rank[i] + tlbt_pkg::RANK_W'(1);
      end
      rank[hit_idx] <= tlbt_pkg::RANK_W'(1);
    end else if (cmd.tlb_ins) begin
      for (int i = 0; i < NT; i++) begin
        if (rank[i] != '0 && rank[i] < tlbt_pkg::RANK_W'(NT)) begin
          rank[i] <= rank[i] + tlbt_pkg::RANK_W'(1);
        end
      end
      rank[ins_idx] <= tlbt_pkg::RANK_W'(1);
    end else if (cmd.evict && rm_any) begin
      for (int i = 0; i < NT; i++) begin
        if (rank[i] > rank[rm_idx]) rank[i] <= rank[i] - tlbt_pkg::RANK_W'(1);
      end
      rank[rm_idx] <= '0;
    end
  end

  // tlb tags and frames
  always_ff @(posedge clk) begin
    if (cmd.tlb_ins) begin
      tag[ins_idx] <= page_q;
      tfr[ins_idx] <= frame_q;
    end
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (cmd.fill) pmap_mem[page_q] <= frame_q;
    pmap_rd <= pmap_mem[page_q];
  end

  // reverse map memory, read at the lru tail
  always_ff @(posedge clk) begin
    if (cmd.fill) fpage_mem[frame_q] <= page_q;
    fpage_rd <= fpage_mem[tail];
  end

  // lru forward links
  always_ff @(posedge clk) begin
    if (cmd.push || cmd.mv_link) begin
      fnext_mem[frame_q] <= head;
    end else if (cmd.mv_unlink) begin
      fnext_mem[fprev_rd] <= fnext_rd;
    end
    fnext_rd <= fnext_mem[frame_q];
  end

  // lru backward links
  always_ff @(posedge clk) begin
    if ((cmd.push && frame_q != '0) || cmd.mv_link) begin
      fprev_mem[head] <= frame_q;
    end else if (cmd.mv_unlink && frame_q != tail) begin
      fprev_mem[fnext_rd] <= fprev_rd;
    end
    fprev_rd <= fprev_mem[frame_q];
  end

  // resident bits, list ends, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid    <= '0;
      head      <= '0;
      tail      <= '0;
      next_free <= '0;
      hit_cnt   <= '0;
      fault_cnt <= '0;
    end else begin
      if (cmd.lookup) begin
        if (hit_any) begin
          hit_cnt <= hit_cnt + tlbt_pkg::CNT_W'(1);
        end else if (!pvalid[page_q]) begin
          fault_cnt <= fault_cnt + tlbt_pkg::CNT_W'(1);
          if (stat.free_avail) next_free <= next_free + tlbt_pkg::FREE_W'(1);
        end
      end
      if (cmd.evict) pvalid[fpage_rd] <= 1'b0;
      if (cmd.fill) pvalid[page_q] <= 1'b1;
      if (cmd.push) begin
        head <= frame_q;
        if (frame_q == '0) tail <= frame_q;
      end
      if (cmd.mv_unlink && frame_q == tail) tail <= fprev_rd;
      if (cmd.mv_link) head <= frame_q;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      page_q     <= va_in[tlbt_pkg::OFFSET_BITS +: tlbt_pkg::PAGE_W];
      off_q      <= va_in[tlbt_pkg::OFFSET_BITS-1:0];
      hit_q      <= 1'b0;
      fault_q    <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
    end
    if (cmd.lookup) begin
      if (hit_any) begin
        hit_q   <= 1'b1;
        frame_q <= tfr[hit_idx];
      end else if (!pvalid[page_q]) begin
        fault_q <= 1'b1;
        frame_q <= stat.free_avail ? next_free[tlbt_pkg::FRAME_W-1:0] : tail;
      end
    end
    if (cmd.pt_load) frame_q <= pmap_rd;
    if (cmd.evict) begin
      ev_valid_q <= 1'b1;
      ev_page_q  <= fpage_rd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pa          <= tlbt_pkg::PA_W'({frame_q, off_q});
      out_hit         <= hit_q;
      out_fault       <= fault_q;
      out_ev_valid    <= ev_valid_q;
      out_ev_page     <= 8'(ev_page_q);
      out_hit_total   <= hit_cnt;
      out_fault_total <= fault_cnt;
    end
  end

endmodule

// ===== hw/rtl/tlbt_checker.sv =====
// port checks of the tlb translator and their bind
`include "assert_macros.svh"

module tlbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tlb_hit,
  input logic       page_fault,
  input logic       evicted_valid,
  input logic [7:0] evicted_page
);

  // a stalled result stays offered
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // a tlb hit is never a fault
  `CHK_SAME(a_hit_no_fault, clk, rst, out_valid && tlb_hit, !page_fault)
  // eviction only happens on a fault
  `CHK_SAME(a_evict_fault, clk, rst, out_valid && evicted_valid, page_fault)
  // no eviction reports page zero
  `CHK_SAME(a_evict_page_zero, clk, rst, out_valid && !evicted_valid, evicted_page == 8'd0)

endmodule

bind tlb_page_table_lru_translator tlbt_checker u_tlbt_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .tlb_hit       (out_ch.tlb_hit),
  .page_fault    (out_ch.page_fault),
  .evicted_valid (out_ch.evicted_valid),
  .evicted_page  (out_ch.evicted_page)
);

// ===== tb/tlbt_tb_pkg.sv =====
`timescale 1ns / 100ps
// address translation predictor and result scoreboard for the tlb translator testbench
package tlbt_tb_pkg;
  import tlbt_pkg::*;

  typedef struct packed {
    logic [PA_W-1:0]  physical_address;
    logic             tlb_hit;
    logic             page_fault;
    logic             evicted_valid;
    logic [7:0]       evicted_page;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] fault_total;
  } xlate_t;

  class xlate_scoreboard;
    page_t  tlb_tag  [TLB_ENTRIES];
    frame_t tlb_frm  [TLB_ENTRIES];
    int     tlb_rnk  [TLB_ENTRIES];
    frame_t pg_frame [PAGE_COUNT];
    bit     pg_valid [PAGE_COUNT];
    int     frm_rnk  [FRAME_COUNT];
    int     free_next;
    count_t hits;
    count_t faults;
    xlate_t pending[$];
    int     errors;

    function new();
      foreach (tlb_rnk[i]) begin
        tlb_tag[i] = '0; tlb_frm[i] = '0; tlb_rnk[i] = 0;
      end
      foreach (pg_valid[i]) begin
        pg_frame[i] = '0; pg_valid[i] = 0;
      end
      foreach (frm_rnk[i]) frm_rnk[i] = 0;
      free_next = 0; hits = '0; faults = '0; errors = 0;
    endfunction

    // new tlb entry: first empty slot, else the oldest
    function void tlb_fill(page_t pg, frame_t fr);
      int e;
      e = -1;
      foreach (tlb_rnk[i]) if (e < 0 && tlb_rnk[i] == 0) e = i;
      foreach (tlb_rnk[i]) if (e < 0 && tlb_rnk[i] == TLB_ENTRIES) e = i;
      if (e < 0) e = 0;
      tlb_tag[e] = pg; tlb_frm[e] = fr;
      foreach (tlb_rnk[i]) if (tlb_rnk[i] > 0 && tlb_rnk[i] < TLB_ENTRIES) tlb_rnk[i]++;
      tlb_rnk[e] = 1;
    endfunction

    // drop the entry of an evicted page and close the rank gap
    function void tlb_drop(page_t pg, frame_t fr);
      int e;
      e = -1;
      foreach (tlb_rnk[i])
        if (e < 0 && tlb_rnk[i] != 0 && tlb_tag[i] == pg && tlb_frm[i] == fr) e = i;
      if (e < 0) return;
      foreach (tlb_rnk[i]) if (tlb_rnk[i] > tlb_rnk[e]) tlb_rnk[i]--;
      tlb_rnk[e] = 0;
    endfunction

    // note an accepted address and queue its expected result
    function void note_address(logic [VA_W-1:0] va);
      page_t  pg;
      frame_t fr;
      xlate_t r;
      int e, f, p, old;
      pg = va[VA_W-1:OFFSET_BITS];
      r = '0;
      e = -1;
      foreach (tlb_rnk[i]) if (e < 0 && tlb_rnk[i] > 0 && tlb_tag[i] == pg) e = i;
      if (e >= 0) begin
        r.tlb_hit = 1; hits++;
        old = tlb_rnk[e];
        foreach (tlb_rnk[i]) if (tlb_rnk[i] > 0 && tlb_rnk[i] < old) tlb_rnk[i]++;
        tlb_rnk[e] = 1;
        fr = tlb_frm[e];
      end else if (pg_valid[pg]) begin
        fr = pg_frame[pg];
        tlb_fill(pg, fr);
      end else begin
        r.page_fault = 1; faults++;
        if (free_next < FRAME_COUNT) begin
          f = free_next; free_next++;
        end else begin
          f = -1; p = -1;
          foreach (frm_rnk[i]) if (f < 0 && frm_rnk[i] == FRAME_COUNT) f = i;
          if (f < 0) f = 0;
          foreach (pg_valid[i]) if (p < 0 && pg_valid[i] && pg_frame[i] == f) p = i;
          if (p >= 0) begin
            pg_valid[p] = 0;
            tlb_drop(page_t'(p), frame_t'(f));
            r.evicted_valid = 1; r.evicted_page = 8'(p);
          end
        end
        foreach (frm_rnk[i]) if (frm_rnk[i] > 0 && frm_rnk[i] < FRAME_COUNT) frm_rnk[i]++;
        frm_rnk[f] = 1;
        fr = frame_t'(f);
        pg_frame[pg] = fr; pg_valid[pg] = 1;
        tlb_fill(pg, fr);
      end
      // every access makes the frame the most recent
      old = frm_rnk[fr];
      foreach (frm_rnk[i]) if (frm_rnk[i] > 0 && frm_rnk[i] < old) frm_rnk[i]++;
      frm_rnk[fr] = 1;
      r.physical_address = PA_W'({fr, va[OFFSET_BITS-1:0]});
      r.hit_total = hits; r.fault_total = faults;
      pending.push_back(r);
    endfunction

    // compare a result with the oldest expectation
    function void check_result(xlate_t got);
      xlate_t w;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.physical_address !== w.physical_address) begin
        $display("%0t physical_address exp %h got %h", $time, w.physical_address,
                 got.physical_address); errors++;
      end
      if (got.tlb_hit !== w.tlb_hit) begin
        $display("%0t tlb_hit exp %b got %b", $time, w.tlb_hit, got.tlb_hit); errors++;
      end
      if (got.page_fault !== w.page_fault) begin
        $display("%0t page_fault exp %b got %b", $time, w.page_fault, got.page_fault);
        errors++;
      end
      if (got.evicted_valid !== w.evicted_valid) begin
        $display("%0t evicted_valid exp %b got %b", $time, w.evicted_valid,
                 got.evicted_valid); errors++;
      end
      if (got.evicted_page !== w.evicted_page) begin
        $display("%0t evicted_page exp %h got %h", $time, w.evicted_page, got.evicted_page);
        errors++;
      end
      if (got.hit_total !== w.hit_total) begin
        $display("%0t hit_total exp %0d got %0d", $time, w.hit_total, got.hit_total);
        errors++;
      end
      if (got.fault_total !== w.fault_total) begin
        $display("%0t fault_total exp %0d got %0d", $time, w.fault_total, got.fault_total);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== tb/tb_tlb_page_table_lru_translator.sv =====
`timescale 1ns / 100ps
// top of the tlb translator testbench: stimulus, result monitor and run control
module tb_tlb_page_table_lru_translator;
  import tlbt_pkg::*;
  import tlbt_tb_pkg::*;

  logic clk;
  logic rst;
  bit   stim_done;
  bit   hold_off;

  tlbt_in_if  in_ch ();
  tlbt_out_if out_ch ();

  xlate_scoreboard sb;

  tlb_page_table_lru_translator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // random gap, mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // offer one address and wait for its transfer; valid stays up between
  // back to back addresses and drops only for a gap
  task automatic send_address(logic [VA_W-1:0] va, bit idle_ok);
    int g;
    g = idle_ok ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.virtual_address <= va;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_address(va);
  endtask

  // page with a working set: reuse recent pages so hits and page-table hits occur
  function automatic logic [VA_W-1:0] pick_address(int mode);
    logic [7:0] pg;
    case (mode)
      0: pg = 8'($urandom_range(11));
      1: pg = 8'($urandom_range(40));
      2: pg = 8'($urandom_range(150));
      default: pg = 8'($urandom());
    endcase
    return {pg, 8'($urandom())};
  endfunction

  // sender
  initial begin
    int n;
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.virtual_address = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, tlb hits, repeats, page-table hit after tlb overflow
    send_address(16'h0000, 0);
    send_address(16'h00ff, 0);
    send_address(16'hffff, 0);
    send_address(16'hff00, 0);
    send_address(16'h0000, 0);
    send_address(16'haa55, 0);
    send_address(16'h55aa, 0);
    for (n = 1; n <= 17; n++) send_address({8'(n), 8'(n * 13)}, 0);
    send_address(16'h0000, 0);
    // fill every frame, then force evictions
    for (n = 0; n < 140; n++) send_address({8'(n + 100), 8'($urandom())}, 1);
    send_address(16'hff80, 0);
    // long receiver hold-off while input keeps coming
    hold_off = 1;
    for (n = 0; n < 20; n++) send_address(pick_address(0), 0);
    hold_off = 0;
    // random
    for (n = 0; n < 340; n++) send_address(pick_address($urandom_range(3)), 1);
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // receiver
  initial begin
    int g;
    int k;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (k = 0; k < 60; k++) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    xlate_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.physical_address = out_ch.physical_address;
      got.tlb_hit = out_ch.tlb_hit;
      got.page_fault = out_ch.page_fault;
      got.evicted_valid = out_ch.evicted_valid;
      got.evicted_page = out_ch.evicted_page;
      got.hit_total = out_ch.hit_total;
      got.fault_total = out_ch.fault_total;
      sb.check_result(got);
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
